### design/cal_pkg.sv
`timescale 1ns / 1ps
// cal_pkg: shared types, register codes and reset values for the cross arm length block
// no dependencies; imported by every cal_* module and by cross_arm_length_top

package cal_pkg;

   // one pixel color, 8 bits per channel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // one input item as held in the input register
   typedef struct packed {
      logic       first;
      logic       off_image;
      rgb_type    color;
      logic [7:0] mask;
   } pix_type;

   // width of nine times a sum of squared channel differences (max 1755675)
   localparam int DIST_W = 21;
   // width of 100 * tau * tau (max 6502500)
   localparam int THR_W  = 23;

   // configuration as seen by the arm logic
   typedef struct packed {
      logic [6:0]       arm_short;
      logic [7:0]       long_limit;
      logic [THR_W-1:0] thr_inner;
      logic [THR_W-1:0] thr_outer;
   } csr_type;

   // register indexes on the configuration port
   typedef enum logic [1:0] {
      CSR_ARM_SHORT = 2'd0,
      CSR_TAU_INNER = 2'd1,
      CSR_TAU_OUTER = 2'd2
   } csr_idx_type;

   localparam logic [6:0]       ARM_SHORT_RST    = 7'd17;
   localparam logic [15:0]      TAU_INNER_SQ_RST = 16'd400;
   localparam logic [15:0]      TAU_OUTER_SQ_RST = 16'd36;
   localparam logic [THR_W-1:0] THR_INNER_RST    = 23'd40000;
   localparam logic [THR_W-1:0] THR_OUTER_RST    = 23'd3600;

   localparam logic [7:0] MASK_FULL = 8'hFF;
   localparam logic [7:0] LONG_CAP  = 8'd128;

   // 100 * x as shifts and adds (64 + 32 + 4)
   function automatic logic [THR_W-1:0] scale100(input logic [15:0] x);
      logic [THR_W-1:0] xe;
      xe = {{(THR_W-16){1'b0}}, x};
      return (xe << 6) + (xe << 5) + (xe << 2);
   endfunction

endpackage

### design/cal_csr.sv
`timescale 1ns / 1ps
// cal_csr: configuration registers and the squared color thresholds derived from them
// depends on cal_pkg

module cal_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_data,
   output cal_pkg::csr_type     csr_cfg
);
   import cal_pkg::*;

   logic [6:0]       arm_short_ff;
   logic [15:0]      tau_inner_sq_ff;
   logic [15:0]      tau_outer_sq_ff;
   logic [THR_W-1:0] thr_inner_ff;
   logic [THR_W-1:0] thr_outer_ff;
   logic [15:0]      data_sq;

   // square of the written threshold, taken at the write
   assign data_sq = csr_data * csr_data;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         arm_short_ff    <= ARM_SHORT_RST;
         tau_inner_sq_ff <= TAU_INNER_SQ_RST;
         tau_outer_sq_ff <= TAU_OUTER_SQ_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ARM_SHORT: arm_short_ff    <= csr_data[6:0];
            CSR_TAU_INNER: tau_inner_sq_ff <= data_sq;
            CSR_TAU_OUTER: tau_outer_sq_ff <= data_sq;
            default: ;
         endcase
      end
   end

   // scaled thresholds, registered from the squares
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_inner_ff <= THR_INNER_RST;
         thr_outer_ff <= THR_OUTER_RST;
      end else begin
         thr_inner_ff <= scale100(tau_inner_sq_ff);
         thr_outer_ff <= scale100(tau_outer_sq_ff);
      end
   end

   // long limit is twice the short limit, capped at 128
   always_comb begin
      csr_cfg.arm_short  = arm_short_ff;
      csr_cfg.long_limit = arm_short_ff[6] ? LONG_CAP : {arm_short_ff, 1'b0};
      csr_cfg.thr_inner  = thr_inner_ff;
      csr_cfg.thr_outer  = thr_outer_ff;
   end

endmodule

### design/cal_dist.sv
`timescale 1ns / 1ps
// cal_dist: nine times the sum of squared channel differences of two colors
// depends on cal_pkg

module cal_dist (
   input  cal_pkg::rgb_type              color_a,
   input  cal_pkg::rgb_type              color_b,
   output logic [cal_pkg::DIST_W-1:0]    dist9
);
   import cal_pkg::*;

   logic [7:0]  diff_r, diff_g, diff_b;
   logic [15:0] sq_r, sq_g, sq_b;
   logic [17:0] sum_sq;

   // absolute channel differences
   assign diff_r = (color_a.red   > color_b.red)   ? color_a.red   - color_b.red
                                                   : color_b.red   - color_a.red;
   assign diff_g = (color_a.green > color_b.green) ? color_a.green - color_b.green
                                                   : color_b.green - color_a.green;
   assign diff_b = (color_a.blue  > color_b.blue)  ? color_a.blue  - color_b.blue
                                                   : color_b.blue  - color_a.blue;

   // squares and sum
   assign sq_r   = diff_r * diff_r;
   assign sq_g   = diff_g * diff_g;
   assign sq_b   = diff_b * diff_b;
   assign sum_sq = {2'b00, sq_r} + {2'b00, sq_g} + {2'b00, sq_b};

   // times nine as shift and add
   assign dist9 = ({3'b000, sum_sq} << 3) + {3'b000, sum_sq};

endmodule

### design/cal_arm.sv
`timescale 1ns / 1ps
// cal_arm: arm state (center, previous color, count, active) and the per-item decision
// depends on cal_pkg and cal_dist

module cal_arm (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  cal_pkg::pix_type  pix,
   input  cal_pkg::csr_type  csr_cfg,
   output logic              emit,
   output logic [6:0]        arm_len
);
   import cal_pkg::*;

   rgb_type           center_ff, center_in;
   rgb_type           prev_ff, prev_in;
   logic [6:0]        step_ff, step_in;
   logic              active_ff, active_in;
   logic [DIST_W-1:0] cen9, pre9;
   logic [7:0]        dist_next;
   logic              extend_ok;

   // distances to the center and to the previous pixel
   cal_dist u_dist_cen (
      .color_a (pix.color),
      .color_b (center_ff),
      .dist9   (cen9)
   );

   cal_dist u_dist_pre (
      .color_a (pix.color),
      .color_b (prev_ff),
      .dist9   (pre9)
   );

   // extension test for the neighbor at distance step + 1
   assign dist_next = {1'b0, step_ff} + 8'd1;
   assign extend_ok = !pix.off_image && (pix.mask != 8'd0)
                      && (dist_next < csr_cfg.long_limit)
                      && ({2'b00, cen9} < csr_cfg.thr_inner)
                      && ({2'b00, pre9} < csr_cfg.thr_inner)
                      && ((dist_next <= {1'b0, csr_cfg.arm_short})
                          || ({2'b00, cen9} < csr_cfg.thr_outer));

   // next state and result
   always_comb begin
      center_in = center_ff;
      prev_in   = prev_ff;
      step_in   = step_ff;
      active_in = active_ff;
      emit      = 1'b0;
      arm_len   = step_ff;
      if (step_en) begin
         if (pix.first) begin
            step_in = 7'd0;
            if (pix.off_image || (pix.mask != MASK_FULL)) begin
               // invalid center ends at once with length zero
               active_in = 1'b0;
               emit      = 1'b1;
               arm_len   = 7'd0;
            end else begin
               center_in = pix.color;
               prev_in   = pix.color;
               active_in = 1'b1;
            end
         end else if (active_ff) begin
            if (extend_ok) begin
               step_in = dist_next[6:0];
               prev_in = pix.color;
            end else begin
               active_in = 1'b0;
               emit      = 1'b1;
            end
         end
      end
   end

   // arm state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         prev_ff   <= '0;
         step_ff   <= 7'd0;
         active_ff <= 1'b0;
      end else begin
         center_ff <= center_in;
         prev_ff   <= prev_in;
         step_ff   <= step_in;
         active_ff <= active_in;
      end
   end

endmodule

### design/cross_arm_length_top.sv
`timescale 1ns / 1ps
// cross_arm_length_top: cross-based support arm grower for stereo matching
// depends on cal_pkg, cal_csr, cal_dist and cal_arm
//
// Usage: an address walker streams the center pixel of an arm (tuser first set)
// followed by its neighbors in one direction on the req_ channel. The block
// counts how far the arm grows and sends one arm length on the rsp_ channel
// when a neighbor fails the color or mask test, hits the long limit or lies
// off the image. A center with mask other than 255 or off the image gives 0.
// Thresholds and the short limit are written on the csr_ channel while no
// arm is in flight; csr_ready is always high.
// A transfer on req_ is captured in the input register, evaluated there, and
// its result, if any, goes to the result register and shows on rsp_. One
// item per cycle is taken while rsp_ is not stalled, set by the input register
// and the result register each holding one item; the arm state updates in the
// same cycle as the evaluation, so consecutive items see each other's effect.
// When rsp_tready is low with a result waiting, the input register still takes
// one more item and then req_tready drops until the result is taken.
// Reset (synchronous, active high) clears both registers and the arm state
// and restores the register defaults: short limit 17, inner 20, outer 6.

module cross_arm_length_top (
   input  logic        clock,
   input  logic        reset,
   // input pixel stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red, green, blue, mask
   input  logic [1:0]  req_tuser,   // first, off_image
   // arm length results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // arm_length, one zero pad bit
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import cal_pkg::*;

   csr_type    csr_cfg;
   pix_type    s1_pix_ff;
   logic       s1_valid_ff;
   logic       rsp_valid_ff;
   logic [6:0] rsp_len_ff;
   logic       advance;
   logic       step_en;
   logic       req_xfer;
   logic       arm_emit;
   logic [6:0] arm_len;

   assign csr_ready = 1'b1;

   // configuration registers
   cal_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_cfg   (csr_cfg)
   );

   // handshake: the held item moves on whenever the result register is free
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step_en    = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
      end else if (step_en) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_pix_ff.first       <= req_tuser[0];
         s1_pix_ff.off_image   <= req_tuser[1];
         s1_pix_ff.color.red   <= req_tdata[7:0];
         s1_pix_ff.color.green <= req_tdata[15:8];
         s1_pix_ff.color.blue  <= req_tdata[23:16];
         s1_pix_ff.mask        <= req_tdata[31:24];
      end
   end

   // arm state and decision
   cal_arm u_arm (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .pix     (s1_pix_ff),
      .csr_cfg (csr_cfg),
      .emit    (arm_emit),
      .arm_len (arm_len)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en && arm_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && arm_emit) begin
         rsp_len_ff <= arm_len;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_len_ff};

   // reset empties both registers
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !s1_valid_ff))
      else $error("registers not empty after reset");

   // input only stalls while an item is held behind a stalled result
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_tvalid && !rsp_tready))
      else $error("input stalled without cause");

   // a decided result appears on the output in the next cycle
   a_result_load : assert property (@(posedge clock) disable iff (reset)
      (step_en && arm_emit) |=> (rsp_tvalid && (rsp_tdata[6:0] == $past(arm_len))))
      else $error("result not loaded");

endmodule
